// ===== hdl/xbt_pkg.sv =====
// Shared types, codes and constants for the XML byte tokenizer.
// No dependencies; every other file of the block but xbt_if uses this package.
`default_nettype none

package xbt_pkg;

	// Nesting limit; the depth counter is eight bits, so the cap never exceeds 255.
	localparam int MAX_DEPTH = 255;
	localparam logic [7:0] DEPTH_CAP = 8'((MAX_DEPTH < 255) ? MAX_DEPTH : 255);

	// Parser phases
	localparam logic [2:0] PH_NONE      = 3'd0;
	localparam logic [2:0] PH_TAG_OPEN  = 3'd1;
	localparam logic [2:0] PH_ELEM_NAME = 3'd2;
	localparam logic [2:0] PH_PRE_ATTR  = 3'd3;
	localparam logic [2:0] PH_ATTR_NAME = 3'd4;
	localparam logic [2:0] PH_PRE_VALUE = 3'd5;
	localparam logic [2:0] PH_VALUE     = 3'd6;
	localparam logic [2:0] PH_CONTENT   = 3'd7;

	// Byte roles
	localparam logic [2:0] ROLE_MARKUP     = 3'd0;
	localparam logic [2:0] ROLE_ELEM_NAME  = 3'd1;
	localparam logic [2:0] ROLE_ATTR_NAME  = 3'd2;
	localparam logic [2:0] ROLE_ATTR_VALUE = 3'd3;
	localparam logic [2:0] ROLE_TEXT       = 3'd4;

	// Delimiters
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] depth;
		logic       all_white;
	} state_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic [2:0] role;
		logic       open_item;
		logic       begin_event;
		logic       end_event;
		logic       text_event;
		logic       text_white;
		logic       text_clear;
		logic [7:0] event_depth;
		logic       depth_error;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/xbt_if.sv =====
// Valid/ready channel interfaces: document bytes in, token beats out.
// Depends on nothing; field names follow the block's item definitions.
`default_nettype none

interface xbt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface xbt_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic [2:0] role;
	logic       open_item;
	logic       begin_event;
	logic       end_event;
	logic       text_event;
	logic       text_white;
	logic       text_clear;
	logic [7:0] event_depth;
	logic       depth_error;

	modport source (output valid, output char_out, output role, output open_item,
		output begin_event, output end_event, output text_event, output text_white,
		output text_clear, output event_depth, output depth_error, input ready);
	modport sink (input valid, input char_out, input role, input open_item,
		input begin_event, input end_event, input text_event, input text_white,
		input text_clear, input event_depth, input depth_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/xbt_step.sv =====
// One tokenizer step: next parser state and the token for one byte.
// Purely combinational; depends on xbt_pkg.
`default_nettype none

module xbt_step (
	input  wire xbt_pkg::state_t  cur,
	input  wire logic [7:0]       char_in,
	output xbt_pkg::state_t       nxt,
	output xbt_pkg::result_t      res
);

	logic sp;

	assign sp = xbt_pkg::is_space(char_in);

	always_comb begin
		nxt = cur;
		res = '0;
		res.char_out = char_in;

		unique case (cur.phase)
			xbt_pkg::PH_NONE: begin
				if (char_in == xbt_pkg::CH_LT) begin
					nxt.phase = xbt_pkg::PH_TAG_OPEN;
				end
			end
			xbt_pkg::PH_CONTENT: begin
				if (char_in == xbt_pkg::CH_LT) begin
					res.text_event  = 1'b1;
					res.text_white  = cur.all_white;
					res.event_depth = (cur.depth != 8'd0) ? cur.depth - 8'd1 : 8'd0;
					nxt.all_white   = 1'b1;
					nxt.phase       = xbt_pkg::PH_TAG_OPEN;
				end else if (char_in == xbt_pkg::CH_GT) begin
					res.text_clear = 1'b1;
					nxt.all_white  = 1'b1;
				end else begin
					res.role = xbt_pkg::ROLE_TEXT;
					if (!sp) begin
						nxt.all_white = 1'b0;
					end
				end
			end
			xbt_pkg::PH_TAG_OPEN: begin
				if (sp) begin
					// skip whitespace after '<'
				end else if (char_in == xbt_pkg::CH_SLASH) begin
					if (cur.depth == 8'd0) begin
						res.depth_error = 1'b1;
						nxt.phase       = xbt_pkg::PH_NONE;
					end else begin
						nxt.depth       = cur.depth - 8'd1;
						res.end_event   = 1'b1;
						res.event_depth = cur.depth - 8'd1;
						nxt.phase = (cur.depth == 8'd1) ? xbt_pkg::PH_NONE
							: xbt_pkg::PH_CONTENT;
					end
				end else begin
					res.role      = xbt_pkg::ROLE_ELEM_NAME;
					res.open_item = 1'b1;
					nxt.phase     = xbt_pkg::PH_ELEM_NAME;
				end
			end
			xbt_pkg::PH_ELEM_NAME, xbt_pkg::PH_PRE_ATTR: begin
				if (sp) begin
					nxt.phase = xbt_pkg::PH_PRE_ATTR;
				end else if (char_in == xbt_pkg::CH_GT) begin
					res.begin_event = 1'b1;
					res.event_depth = cur.depth;
					if (cur.depth >= xbt_pkg::DEPTH_CAP) begin
						res.depth_error = 1'b1;
					end else begin
						nxt.depth = cur.depth + 8'd1;
					end
					nxt.phase = xbt_pkg::PH_CONTENT;
				end else if (char_in == xbt_pkg::CH_SLASH
						|| char_in == xbt_pkg::CH_QMARK) begin
					// self-closing: open and close together, depth holds
					res.begin_event = 1'b1;
					res.end_event   = 1'b1;
					res.event_depth = cur.depth;
					nxt.phase = (cur.depth == 8'd0) ? xbt_pkg::PH_NONE
						: xbt_pkg::PH_CONTENT;
				end else if (cur.phase == xbt_pkg::PH_ELEM_NAME) begin
					res.role = xbt_pkg::ROLE_ELEM_NAME;
				end else begin
					res.role      = xbt_pkg::ROLE_ATTR_NAME;
					res.open_item = 1'b1;
					nxt.phase     = xbt_pkg::PH_ATTR_NAME;
				end
			end
			xbt_pkg::PH_ATTR_NAME: begin
				if (sp) begin
					// drop whitespace inside the name
				end else if (char_in == xbt_pkg::CH_EQ) begin
					nxt.phase = xbt_pkg::PH_PRE_VALUE;
				end else begin
					res.role = xbt_pkg::ROLE_ATTR_NAME;
				end
			end
			xbt_pkg::PH_PRE_VALUE: begin
				if (char_in == xbt_pkg::CH_QUOTE) begin
					res.role      = xbt_pkg::ROLE_ATTR_VALUE;
					res.open_item = 1'b1;
					nxt.phase     = xbt_pkg::PH_VALUE;
				end
			end
			xbt_pkg::PH_VALUE: begin
				if (char_in == xbt_pkg::CH_QUOTE) begin
					nxt.phase = xbt_pkg::PH_PRE_ATTR;
				end else begin
					res.role = xbt_pkg::ROLE_ATTR_VALUE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/xbt_out_fifo.sv =====
// Two-entry result queue that drives the token channel.
// Decouples input acceptance from output back-pressure; depends on xbt_pkg.
`default_nettype none

module xbt_out_fifo (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire logic              push,
	input  wire xbt_pkg::result_t  push_data,
	output logic                   full,
	xbt_token_if.source            tokens
);

	xbt_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;
	xbt_pkg::result_t head;

	assign full = (count_q == 2'd2);
	assign pop  = (count_q != 2'd0) && tokens.ready;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign tokens.valid       = (count_q != 2'd0);
	assign tokens.char_out    = head.char_out;
	assign tokens.role        = head.role;
	assign tokens.open_item   = head.open_item;
	assign tokens.begin_event = head.begin_event;
	assign tokens.end_event   = head.end_event;
	assign tokens.text_event  = head.text_event;
	assign tokens.text_white  = head.text_white;
	assign tokens.text_clear  = head.text_clear;
	assign tokens.event_depth = head.event_depth;
	assign tokens.depth_error = head.depth_error;

endmodule

`default_nettype wire

// ===== hdl/xml_byte_tokenizer_core.sv =====
// Top level of the XML byte tokenizer: parser state registers, step logic
// and result queue. Depends on xbt_pkg, xbt_if, xbt_step and xbt_out_fifo.
`default_nettype none

// Takes one document byte per beat on chars and returns exactly one token beat
// per byte on tokens, in order. A byte is accepted in every cycle while the
// two-entry result queue has room, so the sustained rate is one byte per clock;
// the update of the phase, depth and whitespace registers is what sets it.
// Each accepted byte's token is registered in the result queue. The queue
// absorbs up to two tokens while tokens.ready is low, after which chars.ready
// drops. Element depth saturates at xbt_pkg::MAX_DEPTH (at most 255).

module xml_byte_tokenizer_core (
	input  wire         clk,
	input  wire         arst_n,
	xbt_char_if.sink    chars,
	xbt_token_if.source tokens
);

	xbt_pkg::state_t  state_q;
	xbt_pkg::state_t  state_nxt;
	xbt_pkg::result_t step_res;
	logic             full;
	logic             accept;

	assign chars.ready = !full;
	assign accept      = chars.valid && !full;

	xbt_step u_step (
		.cur     (state_q),
		.char_in (chars.char_in),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= xbt_pkg::PH_NONE;
			state_q.depth     <= 8'd0;
			state_q.all_white <= 1'b1;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	xbt_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.full      (full),
		.tokens    (tokens)
	);

	a_depth_capped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth <= xbt_pkg::DEPTH_CAP)
		else $error("nesting depth beyond cap");

	a_outside_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == xbt_pkg::PH_NONE |-> state_q.depth == 8'd0)
		else $error("outside any tag with nonzero depth");

	a_content_nested: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == xbt_pkg::PH_CONTENT |-> state_q.depth != 8'd0)
		else $error("in element content at depth zero");

	a_begin_nests: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step_res.begin_event && !step_res.end_event && !step_res.depth_error
		|=> state_q.depth == $past(state_q.depth) + 8'd1)
		else $error("start tag did not advance depth");

	a_token_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> tokens.valid)
		else $error("accepted beat produced no token");

endmodule

`default_nettype wire

// ===== tb/sv/tb_xml_byte_tokenizer_core.sv =====
`timescale 1ns / 100ps
// Testbench for xml_byte_tokenizer_core: streams XML-like byte sequences into the
// char channel and checks every token beat against a behavioural parser model.
// Depends on xbt_pkg, the xbt_if channel interfaces and the core itself.

module tb_xml_byte_tokenizer_core;

	localparam int RANDOM_BYTES = 1800;
	localparam int DEEP_DIVE_AT = 600;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;

	xbt_char_if  chars_if ();
	xbt_token_if tokens_if ();

	xml_byte_tokenizer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.tokens (tokens_if.source)
	);

	logic [7:0]       doc_q[$];
	xbt_pkg::result_t expected_tokens[$];

	// Parser state as the block should hold it
	logic [2:0] model_phase;
	logic [7:0] model_depth;
	logic       model_white;

	int total_bytes;
	int bytes_taken;
	int tokens_checked;
	int fail_count;
	int cycle_count;
	int begins_seen;
	int ends_seen;
	int texts_seen;
	int clears_seen;
	int depth_errors_seen;
	int gen_depth;
	bit byte_taken;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic xbt_pkg::result_t tokenize_byte(input logic [7:0] c);
		xbt_pkg::result_t tok;
		logic             blank;
		logic             open_elem;
		logic             self_close;
		tok = '0;
		tok.char_out = c;
		blank = (c == xbt_pkg::CH_SPACE) || (c == xbt_pkg::CH_TAB) || (c == xbt_pkg::CH_LF);
		open_elem = 1'b0;
		self_close = 1'b0;
		case (model_phase)
			xbt_pkg::PH_NONE: begin
				if (c == xbt_pkg::CH_LT)
					model_phase = xbt_pkg::PH_TAG_OPEN;
			end
			xbt_pkg::PH_CONTENT: begin
				if (c == xbt_pkg::CH_LT) begin
					tok.text_event = 1'b1;
					tok.text_white = model_white;
					tok.event_depth = (model_depth > 8'd0) ? model_depth - 8'd1 : 8'd0;
					model_white = 1'b1;
					model_phase = xbt_pkg::PH_TAG_OPEN;
				end else if (c == xbt_pkg::CH_GT) begin
					tok.text_clear = 1'b1;
					model_white = 1'b1;
				end else begin
					tok.role = xbt_pkg::ROLE_TEXT;
					if (!blank)
						model_white = 1'b0;
				end
			end
			xbt_pkg::PH_TAG_OPEN: begin
				// skip blanks after '<'; anything else but '/' opens the name
				if (!blank) begin
					if (c == xbt_pkg::CH_SLASH) begin
						if (model_depth == 8'd0) begin
							tok.depth_error = 1'b1;
							model_phase = xbt_pkg::PH_NONE;
						end else begin
							model_depth = model_depth - 8'd1;
							tok.end_event = 1'b1;
							tok.event_depth = model_depth;
							model_phase = (model_depth == 8'd0) ? xbt_pkg::PH_NONE
								: xbt_pkg::PH_CONTENT;
						end
					end else begin
						tok.role = xbt_pkg::ROLE_ELEM_NAME;
						tok.open_item = 1'b1;
						model_phase = xbt_pkg::PH_ELEM_NAME;
					end
				end
			end
			xbt_pkg::PH_ELEM_NAME: begin
				if (blank)
					model_phase = xbt_pkg::PH_PRE_ATTR;
				else if (c == xbt_pkg::CH_GT)
					open_elem = 1'b1;
				else if (c == xbt_pkg::CH_SLASH || c == xbt_pkg::CH_QMARK)
					self_close = 1'b1;
				else
					tok.role = xbt_pkg::ROLE_ELEM_NAME;
			end
			xbt_pkg::PH_PRE_ATTR: begin
				if (!blank) begin
					if (c == xbt_pkg::CH_SLASH || c == xbt_pkg::CH_QMARK) begin
						self_close = 1'b1;
					end else if (c == xbt_pkg::CH_GT) begin
						open_elem = 1'b1;
					end else begin
						tok.role = xbt_pkg::ROLE_ATTR_NAME;
						tok.open_item = 1'b1;
						model_phase = xbt_pkg::PH_ATTR_NAME;
					end
				end
			end
			xbt_pkg::PH_ATTR_NAME: begin
				if (!blank) begin
					if (c == xbt_pkg::CH_EQ)
						model_phase = xbt_pkg::PH_PRE_VALUE;
					else
						tok.role = xbt_pkg::ROLE_ATTR_NAME;
				end
			end
			xbt_pkg::PH_PRE_VALUE: begin
				// the opening quote marks the value, so empty values still show
				if (c == xbt_pkg::CH_QUOTE) begin
					tok.role = xbt_pkg::ROLE_ATTR_VALUE;
					tok.open_item = 1'b1;
					model_phase = xbt_pkg::PH_VALUE;
				end
			end
			xbt_pkg::PH_VALUE: begin
				if (c == xbt_pkg::CH_QUOTE)
					model_phase = xbt_pkg::PH_PRE_ATTR;
				else
					tok.role = xbt_pkg::ROLE_ATTR_VALUE;
			end
		endcase
		if (open_elem) begin
			tok.begin_event = 1'b1;
			tok.event_depth = model_depth;
			// hold the depth at the cap and flag it
			if (model_depth >= xbt_pkg::DEPTH_CAP)
				tok.depth_error = 1'b1;
			else
				model_depth = model_depth + 8'd1;
			model_phase = xbt_pkg::PH_CONTENT;
		end
		if (self_close) begin
			tok.begin_event = 1'b1;
			tok.end_event = 1'b1;
			tok.event_depth = model_depth;
			model_phase = (model_depth == 8'd0) ? xbt_pkg::PH_NONE : xbt_pkg::PH_CONTENT;
		end
		return tok;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report($sformatf("token %0d %s got 0x%0h, want 0x%0h", tokens_checked, name,
				got, want));
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endtask

	task automatic add_blanks(input int lo, input int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n) begin
			case ($urandom_range(2, 0))
				0: doc_q.push_back(xbt_pkg::CH_SPACE);
				1: doc_q.push_back(xbt_pkg::CH_TAB);
				default: doc_q.push_back(xbt_pkg::CH_LF);
			endcase
		end
	endtask

	task automatic add_name(input int lo, input int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n)
			doc_q.push_back(8'h61 + 8'($urandom_range(25, 0)));
	endtask

	task automatic add_random_bytes(input int lo, input int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n)
			doc_q.push_back(8'($urandom_range(255, 0)));
	endtask

	task automatic add_start_tag(output bit opened);
		int         n_attr;
		int         v_len;
		logic [7:0] v;
		opened = 1'b0;
		doc_q.push_back(xbt_pkg::CH_LT);
		if ($urandom_range(3, 0) == 0)
			add_blanks(1, 2);
		add_name(1, 4);
		n_attr = $urandom_range(3, 0);
		repeat (n_attr) begin
			add_blanks(1, 2);
			add_name(1, 3);
			if ($urandom_range(3, 0) == 0) begin
				add_blanks(1, 1);
				add_name(1, 2);
			end
			if ($urandom_range(3, 0) == 0)
				add_blanks(1, 1);
			doc_q.push_back(xbt_pkg::CH_EQ);
			if ($urandom_range(3, 0) == 0)
				add_blanks(1, 1);
			doc_q.push_back(xbt_pkg::CH_QUOTE);
			v_len = $urandom_range(5, 0);
			repeat (v_len) begin
				v = 8'($urandom_range(255, 0));
				doc_q.push_back((v == xbt_pkg::CH_QUOTE) ? xbt_pkg::CH_SPACE : v);
			end
			doc_q.push_back(xbt_pkg::CH_QUOTE);
		end
		if ($urandom_range(3, 0) == 0)
			add_blanks(1, 2);
		case ($urandom_range(5, 0))
			0: begin
				doc_q.push_back(xbt_pkg::CH_SLASH);
				doc_q.push_back(xbt_pkg::CH_GT);
			end
			1: begin
				doc_q.push_back(xbt_pkg::CH_QMARK);
				doc_q.push_back(xbt_pkg::CH_GT);
			end
			default: begin
				doc_q.push_back(xbt_pkg::CH_GT);
				opened = 1'b1;
			end
		endcase
	endtask

	task automatic add_text();
		int         n;
		logic [7:0] t;
		if ($urandom_range(2, 0) == 0) begin
			add_blanks(1, 4);
		end else begin
			n = $urandom_range(8, 1);
			repeat (n) begin
				case ($urandom_range(9, 0))
					0, 1, 2: add_blanks(1, 1);
					3, 4, 5, 6: add_name(1, 1);
					7: doc_q.push_back(xbt_pkg::CH_GT);
					default: begin
						t = 8'($urandom_range(255, 0));
						doc_q.push_back((t == xbt_pkg::CH_LT) ? xbt_pkg::CH_QUOTE : t);
					end
				endcase
			end
		end
	endtask

	// Mostly well-formed markup with random content, some noise and cut-off tags,
	// and one dive past the depth cap and back out below zero.
	task automatic add_random_stream(input int count);
		int start_len;
		int pick;
		bit dived;
		bit opened;
		start_len = doc_q.size();
		dived = 1'b0;
		while (doc_q.size() - start_len < count) begin
			if (!dived && gen_depth == 0 && doc_q.size() - start_len >= DEEP_DIVE_AT) begin
				dived = 1'b1;
				repeat (int'(xbt_pkg::DEPTH_CAP) + 4)
					add_str("<a>");
				repeat (int'(xbt_pkg::DEPTH_CAP) + 5)
					add_str("</");
			end
			pick = $urandom_range(99, 0);
			if (pick < 8) begin
				add_random_bytes(1, 6);
			end else if (pick < 16) begin
				doc_q.push_back(xbt_pkg::CH_LT);
				add_random_bytes(1, 5);
			end else if (gen_depth > 0 && (pick < 40 || gen_depth > 5)) begin
				doc_q.push_back(xbt_pkg::CH_LT);
				doc_q.push_back(xbt_pkg::CH_SLASH);
				add_name(1, 4);
				if ($urandom_range(3, 0) == 0)
					add_blanks(1, 1);
				doc_q.push_back(xbt_pkg::CH_GT);
				gen_depth--;
			end else if (pick < 65 || gen_depth == 0) begin
				add_start_tag(opened);
				if (opened)
					gen_depth++;
			end else begin
				add_text();
			end
		end
	endtask

	// Drive bytes at the falling edge; hold a beat until it has been taken.
	always @(negedge clk) begin : feed_bytes
		int stage;
		int idle_pct;
		int stall_pct;
		bit took;
		bit send;
		if (arst_n) begin
			stage = (total_bytes > 0) ? bytes_taken * 4 / total_bytes : 3;
			if (stage > 3)
				stage = 3;
			case (stage)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					idle_pct = 33;
					stall_pct = 33;
				end
			endcase
			took = byte_taken;
			byte_taken = 1'b0;
			if (took)
				doc_q.delete(0);
			if (!chars_if.valid || took) begin
				send = (doc_q.size() > 0) && ($urandom_range(99, 0) >= idle_pct);
				chars_if.valid <= send;
				chars_if.char_in <= send ? doc_q[0] : 8'($urandom);
			end
			tokens_if.ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Sample both channels at the rising edge: check tokens, then predict new bytes.
	always @(posedge clk) begin : watch_beats
		xbt_pkg::result_t want;
		if (arst_n) begin
			if (tokens_if.valid && tokens_if.ready) begin
				if (expected_tokens.size() == 0) begin
					report($sformatf("token beat 0x%0h arrived with nothing expected",
						tokens_if.char_out));
				end else begin
					want = expected_tokens.pop_front();
					check_field("char_out", tokens_if.char_out, want.char_out);
					check_field("role", 8'(tokens_if.role), 8'(want.role));
					check_field("open_item", 8'(tokens_if.open_item), 8'(want.open_item));
					check_field("begin_event", 8'(tokens_if.begin_event), 8'(want.begin_event));
					check_field("end_event", 8'(tokens_if.end_event), 8'(want.end_event));
					check_field("text_event", 8'(tokens_if.text_event), 8'(want.text_event));
					check_field("text_white", 8'(tokens_if.text_white), 8'(want.text_white));
					check_field("text_clear", 8'(tokens_if.text_clear), 8'(want.text_clear));
					check_field("event_depth", tokens_if.event_depth, want.event_depth);
					check_field("depth_error", 8'(tokens_if.depth_error), 8'(want.depth_error));
					begins_seen += want.begin_event;
					ends_seen += want.end_event;
					texts_seen += want.text_event;
					clears_seen += want.text_clear;
					depth_errors_seen += want.depth_error;
				end
				tokens_checked++;
			end
			if (chars_if.valid && chars_if.ready) begin
				expected_tokens.push_back(tokenize_byte(chars_if.char_in));
				bytes_taken++;
				byte_taken = 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d tokens still due", cycle_count,
			expected_tokens.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : run
		clk = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_in = 8'h00;
		tokens_if.ready = 1'b0;
		model_phase = xbt_pkg::PH_NONE;
		model_depth = 8'd0;
		model_white = 1'b1;
		total_bytes = 0;
		bytes_taken = 0;
		tokens_checked = 0;
		fail_count = 0;
		begins_seen = 0;
		ends_seen = 0;
		texts_seen = 0;
		clears_seen = 0;
		depth_errors_seen = 0;
		gen_depth = 0;
		byte_taken = 1'b0;

		// Extreme bytes outside a tag, end tag at depth zero, blank after '<',
		// blank inside an attribute name, empty value, text discard, blank text
		// delivery, '>' as a name start and a '?' self-close.
		doc_q.push_back(8'h00);
		doc_q.push_back(8'hFF);
		add_str("</< r a b=\"\"> x> <><?</");
		add_random_stream(RANDOM_BYTES);
		total_bytes = doc_q.size();

		repeat (2) @(posedge clk);
		#2 arst_n = 1'b1;

		while (bytes_taken < total_bytes)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d bytes over four idle/stall phases, %0d tokens checked.",
			bytes_taken, tokens_checked);
		$display("Events: %0d begin, %0d end, %0d text, %0d clear, %0d depth errors.",
			begins_seen, ends_seen, texts_seen, clears_seen, depth_errors_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== xml_byte_tokenizer_core.f =====
hdl/xbt_pkg.sv
hdl/xbt_if.sv
hdl/xbt_step.sv
hdl/xbt_out_fifo.sv
hdl/xml_byte_tokenizer_core.sv
tb/sv/tb_xml_byte_tokenizer_core.sv
